// ===== rtl/core/nit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nit_pkg
// Shared types and constants of the name interning table: hash constants,
// result status codes, fixed result field widths, controller/datapath bundles.
// ----------------------------------------------------------------------------
package nit_pkg;

  localparam int unsigned HASH_K  = 41;
  localparam int unsigned HASH_K2 = HASH_K * HASH_K;
  localparam int unsigned HASH_K3 = HASH_K * HASH_K * HASH_K;

  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned START_W  = 12;
  localparam int unsigned LENOUT_W = 7;
  localparam int unsigned ID_W     = 10;
  localparam int unsigned STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd4;

  typedef struct packed {
    logic                clr_step;
    logic                take_unit;
    logic                take_empty;
    logic                mid_rd;
    logic                mul;
    logic                sum;
    logic                mod_step;
    logic                head_rd;
    logic                walk_init;
    logic                ent_rd;
    logic                idx_clr;
    logic                cmp_rd;
    logic                idx_inc;
    logic                follow;
    logic                copy_rd;
    logic                copy_wr;
    logic                commit;
    logic                res_load;
    logic [STATUS_W-1:0] res_st;
  } nit_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic too_long;
    logic mod_done;
    logic chain_valid;
    logic len_eq;
    logic len_zero;
    logic char_eq;
    logic idx_last;
    logic copy_done;
    logic pool_full;
    logic table_full;
    logic out_free;
  } nit_sts_t;

endpackage

// ===== rtl/core/nit_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nit_ctrl
// Sequencer of the name interning table: collects units, then steps the
// datapath through hash, bucket reduction, chain walk, compare and insert.
// ----------------------------------------------------------------------------
module nit_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_is_last,
  input  logic              in_empty_name,
  output nit_pkg::nit_cmd_t cmd,
  input  nit_pkg::nit_sts_t sts
);
  import nit_pkg::*;

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_COLLECT = 5'd1;
  localparam logic [4:0] S_MIDRD   = 5'd2;
  localparam logic [4:0] S_MUL     = 5'd3;
  localparam logic [4:0] S_SUM     = 5'd4;
  localparam logic [4:0] S_MOD     = 5'd5;
  localparam logic [4:0] S_HEADRD  = 5'd6;
  localparam logic [4:0] S_HEAD    = 5'd7;
  localparam logic [4:0] S_WALK    = 5'd8;
  localparam logic [4:0] S_ENT     = 5'd9;
  localparam logic [4:0] S_CMPRD   = 5'd10;
  localparam logic [4:0] S_CMPCK   = 5'd11;
  localparam logic [4:0] S_INS     = 5'd12;
  localparam logic [4:0] S_CPYRD   = 5'd13;
  localparam logic [4:0] S_CPYWR   = 5'd14;
  localparam logic [4:0] S_RES     = 5'd15;

  logic [4:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] code_r, code_nxt;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_COLLECT;
      end
      S_COLLECT: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_empty_name) begin
            cmd.take_empty = 1'b1;
            state_nxt      = S_SUM;
          end else begin
            cmd.take_unit = 1'b1;
            if (in_is_last) state_nxt = S_MIDRD;
          end
        end
      end
      S_MIDRD: begin
        if (sts.too_long) begin
          code_nxt  = ST_TOO_LONG;
          state_nxt = S_RES;
        end else begin
          cmd.mid_rd = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (sts.mod_done) state_nxt = S_HEADRD;
        else cmd.mod_step = 1'b1;
      end
      S_HEADRD: begin
        cmd.head_rd = 1'b1;
        state_nxt   = S_HEAD;
      end
      S_HEAD: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        if (sts.chain_valid) begin
          cmd.ent_rd = 1'b1;
          state_nxt  = S_ENT;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_ENT: begin
        if (!sts.len_eq) begin
          cmd.follow = 1'b1;
          state_nxt  = S_WALK;
        end else if (sts.len_zero) begin
          code_nxt  = ST_FOUND;
          state_nxt = S_RES;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_CMPRD;
        end
      end
      S_CMPRD: begin
        cmd.cmp_rd = 1'b1;
        state_nxt  = S_CMPCK;
      end
      S_CMPCK: begin
        if (!sts.char_eq) begin
          cmd.follow = 1'b1;
          state_nxt  = S_WALK;
        end else if (sts.idx_last) begin
          code_nxt  = ST_FOUND;
          state_nxt = S_RES;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CMPRD;
        end
      end
      S_INS: begin
        if (sts.pool_full) begin
          code_nxt  = ST_POOL_FULL;
          state_nxt = S_RES;
        end else if (sts.table_full) begin
          code_nxt  = ST_TABLE_FULL;
          state_nxt = S_RES;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_CPYRD;
        end
      end
      S_CPYRD: begin
        if (sts.copy_done) begin
          code_nxt  = ST_INSERTED;
          state_nxt = S_RES;
        end else begin
          cmd.copy_rd = 1'b1;
          state_nxt   = S_CPYWR;
        end
      end
      S_CPYWR: begin
        cmd.copy_wr = 1'b1;
        state_nxt   = S_CPYRD;
      end
      S_RES: begin
        cmd.res_st = code_r;
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          cmd.commit   = (code_r == ST_INSERTED);
          state_nxt    = S_COLLECT;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      code_r  <= ST_FOUND;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

// ===== rtl/core/nit_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nit_dp
// Datapath of the name interning table: name buffer, character pool, entry
// and bucket memories, hash and bucket reduction, compare and result register.
// ----------------------------------------------------------------------------
module nit_dp #(
  parameter int unsigned POOL_SIZE    = 4096,
  parameter int unsigned HASH_BUCKETS = 256,
  parameter int unsigned MAX_ENTRIES  = 1024,
  parameter int unsigned MAX_NAME_LEN = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nit_pkg::nit_cmd_t               cmd,
  output nit_pkg::nit_sts_t               sts,
  input  logic [nit_pkg::UNIT_W-1:0]      in_code_unit,
  input  logic                            in_is_last,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [nit_pkg::START_W-1:0]     out_name_start,
  output logic [nit_pkg::LENOUT_W-1:0]    out_name_length,
  output logic [nit_pkg::ID_W-1:0]        out_entry_id,
  output logic [nit_pkg::STATUS_W-1:0]    out_status
);
  import nit_pkg::*;

  localparam int unsigned PW  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned PW1 = PW + 1;
  localparam int unsigned EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned EW1 = EW + 1;
  localparam int unsigned HW  = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
  localparam int unsigned LW  = $clog2(MAX_NAME_LEN + 2);
  localparam int unsigned BIW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int unsigned AW  = ((PW > LW) ? PW : LW) + 1;
  localparam bit IS_POW2 = ((HASH_BUCKETS & (HASH_BUCKETS - 1)) == 0);
  // hash stays below 2^28 for any legal name length
  localparam int unsigned RW  = 28;
  localparam int unsigned SH  = RW + HW;
  localparam int unsigned PRW = 2 * RW + 1;
  localparam int unsigned QBW = RW + 17;
  localparam logic [RW:0] RECIP = (RW+1)'((64'd1 << SH) / 64'(HASH_BUCKETS));

  // memories
  logic [UNIT_W-1:0] name_buf   [MAX_NAME_LEN];
  logic [UNIT_W-1:0] char_pool  [POOL_SIZE];
  logic [PW-1:0]     ent_start_m[MAX_ENTRIES];
  logic [LW-1:0]     ent_len_m  [MAX_ENTRIES];
  logic [EW:0]       ent_link_m [MAX_ENTRIES];
  logic [EW:0]       head_m     [HASH_BUCKETS];

  // control registers
  logic [LW-1:0]     fill_r, fill_nxt;
  logic [PW:0]       pool_next_r, pool_next_nxt;
  logic [EW:0]       count_r, count_nxt;
  logic [HW-1:0]     clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;

  // datapath registers
  logic [LW-1:0]     len_r;
  logic [UNIT_W-1:0] first_r, last_r, mid_r, buf_q, pool_q;
  logic [31:0]       p_len_r, p_first_r, p_last_r, rem_r;
  logic [PRW-1:0]    prod_r;
  logic [RW-1:0]     qb_r;
  logic [2:0]        cnt_r;
  logic [EW:0]       head_q;
  logic [EW-1:0]     e_r;
  logic              ev_r;
  logic [PW-1:0]     ent_start_q;
  logic [LW-1:0]     ent_len_q;
  logic [EW:0]       ent_link_q;
  logic [LW-1:0]     idx_r;
  logic              oob_r;
  logic [START_W-1:0]  res_start_r;
  logic [LENOUT_W-1:0] res_len_r;
  logic [ID_W-1:0]     res_id_r;
  logic [STATUS_W-1:0] res_st_r;

  logic [LW-1:0]     fill_step, half_len, need;
  logic [BIW-1:0]    buf_ra;
  logic [AW-1:0]     cmp_addr;
  logic [PW:0]       wr_addr;
  logic [HW-1:0]     bucket;
  logic              hd_we;
  logic [HW-1:0]     hd_wa;
  logic [EW:0]       hd_wd;

  always_comb begin
    fill_step = (fill_r < LW'(MAX_NAME_LEN)) ? fill_r + LW'(1) : LW'(MAX_NAME_LEN + 1);
    half_len  = len_r >> 1;
    buf_ra    = cmd.mid_rd ? half_len[BIW-1:0] : idx_r[BIW-1:0];
    cmp_addr  = AW'(ent_start_q) + AW'(idx_r);
    wr_addr   = pool_next_r + PW1'(idx_r);
    bucket    = rem_r[HW-1:0];
    need      = (len_r == '0) ? LW'(1) : len_r;
    hd_we     = cmd.clr_step | cmd.commit;
    hd_wa     = cmd.clr_step ? clr_r : bucket;
    hd_wd     = cmd.clr_step ? '0 : {1'b1, count_r[EW-1:0]};
  end

  // next state of control registers
  always_comb begin
    fill_nxt      = fill_r;
    pool_next_nxt = pool_next_r;
    count_nxt     = count_r;
    clr_nxt       = clr_r;
    out_valid_nxt = cmd.res_load | (out_valid_r & out_stall);
    if (cmd.take_empty) fill_nxt = '0;
    else if (cmd.take_unit) fill_nxt = in_is_last ? '0 : fill_step;
    if (cmd.commit) begin
      pool_next_nxt = pool_next_r + PW1'(need);
      count_nxt     = count_r + EW1'(1);
    end
    if (cmd.clr_step) clr_nxt = clr_r + HW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      pool_next_r <= '0;
      count_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      pool_next_r <= pool_next_nxt;
      count_r     <= count_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // name buffer
  always_ff @(posedge clk) begin
    if (cmd.take_unit && (fill_r < LW'(MAX_NAME_LEN))) name_buf[fill_r[BIW-1:0]] <= in_code_unit;
    if (cmd.mid_rd || cmd.cmp_rd || cmd.copy_rd) buf_q <= name_buf[buf_ra];
  end

  // character pool
  always_ff @(posedge clk) begin
    if (cmd.copy_wr) char_pool[wr_addr[PW-1:0]] <= buf_q;
    if (cmd.cmp_rd) begin
      pool_q <= char_pool[cmp_addr[PW-1:0]];
      oob_r  <= (cmp_addr >= AW'(POOL_SIZE));
    end
  end

  // entry table
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ent_start_m[count_r[EW-1:0]] <= pool_next_r[PW-1:0];
      ent_len_m[count_r[EW-1:0]]   <= len_r;
      ent_link_m[count_r[EW-1:0]]  <= head_q;
    end
    if (cmd.ent_rd) begin
      ent_start_q <= ent_start_m[e_r];
      ent_len_q   <= ent_len_m[e_r];
      ent_link_q  <= ent_link_m[e_r];
    end
  end

  // bucket heads, valid flag in the top bit
  always_ff @(posedge clk) begin
    if (hd_we) head_m[hd_wa] <= hd_wd;
    if (cmd.head_rd) head_q <= head_m[bucket];
  end

  // name capture, hash and bucket reduction, walk registers
  always_ff @(posedge clk) begin
    if (cmd.take_empty) len_r <= '0;
    if (cmd.take_unit) begin
      if (fill_r == '0) first_r <= in_code_unit;
      last_r <= in_code_unit;
      if (in_is_last) len_r <= fill_step;
    end
    if (cmd.mul) begin
      p_len_r   <= 32'(len_r) * 32'(HASH_K3);
      p_first_r <= 32'(first_r) * 32'(HASH_K2);
      p_last_r  <= 32'(last_r) * 32'(HASH_K);
      mid_r     <= buf_q;
    end
    if (cmd.sum) begin
      rem_r <= (len_r == '0) ? 32'd0 : p_len_r + p_first_r + p_last_r + 32'(mid_r);
      cnt_r <= '0;
    end
    if (cmd.mod_step) begin
      // reciprocal estimate of the quotient, low by at most one, then one fixup
      cnt_r <= cnt_r + 3'd1;
      case (cnt_r)
        3'd0: prod_r <= PRW'(rem_r[RW-1:0]) * PRW'(RECIP);
        3'd1: qb_r <= RW'(QBW'(prod_r[PRW-1:SH]) * QBW'(HASH_BUCKETS));
        3'd2: rem_r <= rem_r - 32'(qb_r);
        3'd3: if (rem_r >= 32'(HASH_BUCKETS)) rem_r <= rem_r - 32'(HASH_BUCKETS);
        default: ;
      endcase
    end
    if (cmd.walk_init) begin
      e_r  <= head_q[EW-1:0];
      ev_r <= head_q[EW];
    end
    if (cmd.follow) begin
      e_r  <= ent_link_q[EW-1:0];
      ev_r <= ent_link_q[EW];
    end
    if (cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_inc || cmd.copy_wr) idx_r <= idx_r + LW'(1);
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_st_r <= cmd.res_st;
      case (cmd.res_st)
        ST_FOUND: begin
          res_start_r <= START_W'(ent_start_q);
          res_len_r   <= LENOUT_W'(len_r);
          res_id_r    <= ID_W'(e_r);
        end
        ST_INSERTED: begin
          res_start_r <= START_W'(pool_next_r);
          res_len_r   <= LENOUT_W'(len_r);
          res_id_r    <= ID_W'(count_r);
        end
        default: begin
          res_start_r <= '0;
          res_len_r   <= '0;
          res_id_r    <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts.clr_done    = (clr_r == HW'(HASH_BUCKETS - 1));
    sts.too_long    = (len_r > LW'(MAX_NAME_LEN));
    sts.mod_done    = IS_POW2 || (cnt_r == 3'd4);
    sts.chain_valid = ev_r;
    sts.len_eq      = (ent_len_q == len_r);
    sts.len_zero    = (len_r == '0);
    sts.char_eq     = !oob_r && (pool_q == buf_q);
    sts.idx_last    = (idx_r == len_r - LW'(1));
    sts.copy_done   = (idx_r == len_r);
    sts.pool_full   = (32'(need) > (32'(POOL_SIZE) - 32'(pool_next_r)));
    sts.table_full  = (count_r >= EW1'(MAX_ENTRIES));
    sts.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_name_start  = res_start_r;
  assign out_name_length = res_len_r;
  assign out_entry_id    = res_id_r;
  assign out_status      = res_st_r;

endmodule

// ===== rtl/core/name_interning_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// name_interning_table_top
// Interns names given one 16-bit code unit per transaction; returns pool
// position, length and entry index, or an error status, once per name.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_stall): one code unit per transaction, in_is_last
//  on the final unit; in_empty_name alone is a complete zero-length name.
//  Units of a name are taken one per cycle. After the last unit the block
//  stalls the input while it processes the name step by step: mid-unit
//  read, products, sum (an empty name skips the first two), bucket
//  reduction (skipped when HASH_BUCKETS is a power of two), head read, walk
//  setup; then a link step and an entry check per chain entry visited, a
//  read and a check per compared unit; on a miss a chain-end check, a room
//  check, a read and a write per unit copied, a final check; last, the
//  result load. An overlong name goes from the length check straight to the
//  result load. Sequencing through shared single-port memories sets the steps.
//  Output channel (out_valid/out_stall): one result transaction per name held
//  in an output register; collection of the next name goes on while it waits,
//  and a finished lookup waits for the register to free up when stalled.
//  Reset: control state clears, then a clearing pass over all HASH_BUCKETS
//  heads empties the bucket table; no input is taken during it.
// ----------------------------------------------------------------------------
module name_interning_table_top #(
  parameter int unsigned POOL_SIZE    = 4096,
  parameter int unsigned HASH_BUCKETS = 256,
  parameter int unsigned MAX_ENTRIES  = 1024,
  parameter int unsigned MAX_NAME_LEN = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [nit_pkg::UNIT_W-1:0]   in_code_unit,
  input  logic                         in_is_last,
  input  logic                         in_empty_name,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nit_pkg::START_W-1:0]  out_name_start,
  output logic [nit_pkg::LENOUT_W-1:0] out_name_length,
  output logic [nit_pkg::ID_W-1:0]     out_entry_id,
  output logic [nit_pkg::STATUS_W-1:0] out_status
);
  import nit_pkg::*;

  nit_cmd_t cmd;
  nit_sts_t sts;

  nit_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_is_last   (in_is_last),
    .in_empty_name(in_empty_name),
    .cmd          (cmd),
    .sts          (sts)
  );

  nit_dp #(
    .POOL_SIZE   (POOL_SIZE),
    .HASH_BUCKETS(HASH_BUCKETS),
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_code_unit   (in_code_unit),
    .in_is_last     (in_is_last),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_name_start (out_name_start),
    .out_name_length(out_name_length),
    .out_entry_id   (out_entry_id),
    .out_status     (out_status)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for name_interning_table_top. Names are queued as code
// unit transactions, each one run through a local intern-table model as it is
// queued. A monitor checks every result against the oldest expected one.
// Directed names first, then a random mix: repeated names, near misses,
// empty names, broken and overlong names. Both channels idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb_top;
  import nit_pkg::*;

  localparam int POOL_N   = 4096;
  localparam int BUCKET_N = 256;
  localparam int ENTRY_N  = 1024;
  localparam int NAME_MAX = 64;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              last;
    logic              empty;
  } unit_item_t;

  typedef struct packed {
    logic [START_W-1:0]  start;
    logic [LENOUT_W-1:0] len;
    logic [ID_W-1:0]     id;
    logic [STATUS_W-1:0] st;
  } intern_res_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [UNIT_W-1:0]   in_code_unit;
  logic                in_is_last;
  logic                in_empty_name;
  logic                out_valid;
  logic                out_stall;
  logic [START_W-1:0]  out_name_start;
  logic [LENOUT_W-1:0] out_name_length;
  logic [ID_W-1:0]     out_entry_id;
  logic [STATUS_W-1:0] out_status;

  name_interning_table_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_code_unit(in_code_unit),
    .in_is_last(in_is_last), .in_empty_name(in_empty_name),
    .out_valid(out_valid), .out_stall(out_stall), .out_name_start(out_name_start),
    .out_name_length(out_name_length), .out_entry_id(out_entry_id),
    .out_status(out_status)
  );

  unit_item_t  unit_q[$];
  intern_res_t interned_q[$];
  int          items_total;
  int          items_taken;
  int          errors;

  // intern table shadow
  logic [15:0] pool_mem [POOL_N];
  int unsigned pool_top;
  logic [ID_W:0] head_idx [BUCKET_N];
  bit          head_ok [BUCKET_N];
  int unsigned ent_start [ENTRY_N];
  int unsigned ent_len [ENTRY_N];
  int unsigned ent_link [ENTRY_N];
  bit          ent_link_ok [ENTRY_N];
  int unsigned ent_cnt;
  logic [15:0] nbuf [NAME_MAX];
  int unsigned nfill;

  // name being built for queueing, plus a library of names for repeats
  logic [15:0] name_w [80];
  logic [15:0] lib_u [48][NAME_MAX];
  int          lib_n [48];
  int          lib_cnt;

  function automatic bit pooled_match(int unsigned start, int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      if (start + i >= POOL_N || pool_mem[start + i] != nbuf[i]) return 0;
    end
    return 1;
  endfunction

  function automatic intern_res_t intern_name(int unsigned len);
    int unsigned h;
    int unsigned b;
    int unsigned e;
    int unsigned steps;
    int unsigned need;
    bit ok;
    intern_res_t r;
    h = 0;
    if (len > 0)
      h = len * HASH_K3 + 32'(nbuf[0]) * HASH_K2
        + 32'(nbuf[len - 1]) * HASH_K + 32'(nbuf[len >> 1]);
    b = h % BUCKET_N;
    ok = head_ok[b];
    e = 32'(head_idx[b]);
    steps = 0;
    r = '0;
    while (ok && e < ENTRY_N && steps <= ent_cnt) begin
      if (ent_len[e] == len && pooled_match(ent_start[e], len)) begin
        r.start = START_W'(ent_start[e]);
        r.len = LENOUT_W'(len);
        r.id = ID_W'(e);
        r.st = ST_FOUND;
        return r;
      end
      ok = ent_link_ok[e];
      e = ent_link[e];
      steps++;
    end
    need = (len == 0) ? 1 : len;
    if (pool_top > POOL_N || need > POOL_N - pool_top) begin
      r.st = ST_POOL_FULL;
      return r;
    end
    if (ent_cnt >= ENTRY_N) begin
      r.st = ST_TABLE_FULL;
      return r;
    end
    for (int unsigned i = 0; i < len; i++) pool_mem[pool_top + i] = nbuf[i];
    e = ent_cnt;
    ent_start[e] = pool_top;
    ent_len[e] = len;
    ent_link[e] = 32'(head_idx[b]);
    ent_link_ok[e] = head_ok[b];
    head_idx[b] = (ID_W+1)'(e);
    head_ok[b] = 1;
    ent_cnt++;
    r.start = START_W'(pool_top);
    r.len = LENOUT_W'(len);
    r.id = ID_W'(e);
    r.st = ST_INSERTED;
    pool_top += need;
    return r;
  endfunction

  // queue one transaction and predict what it causes
  task automatic put_unit(logic [15:0] u, bit last, bit empt);
    unit_item_t it;
    intern_res_t r;
    int unsigned len;
    it.unit = u;
    it.last = last;
    it.empty = empt;
    unit_q.push_back(it);
    items_total++;
    if (empt) begin
      nfill = 0;
      interned_q.push_back(intern_name(0));
    end else begin
      if (nfill < NAME_MAX) begin
        nbuf[nfill] = u;
        nfill++;
      end else begin
        nfill = NAME_MAX + 1;
      end
      if (last) begin
        len = nfill;
        nfill = 0;
        if (len > NAME_MAX) begin
          r = '0;
          r.st = ST_TOO_LONG;
          interned_q.push_back(r);
        end else begin
          interned_q.push_back(intern_name(len));
        end
      end
    end
  endtask

  task automatic put_name(int n);
    for (int i = 0; i < n; i++) put_unit(name_w[i], i == n - 1, 1'b0);
  endtask

  task automatic put_empty();
    put_unit(16'($urandom), 1'($urandom), 1'b1);
  endtask

  task automatic remember_name(int n);
    int slot;
    if (n > NAME_MAX) return;
    if (lib_cnt < 48) begin
      slot = lib_cnt;
      lib_cnt++;
    end else begin
      slot = $urandom_range(0, 47);
    end
    lib_n[slot] = n;
    for (int i = 0; i < n; i++) lib_u[slot][i] = name_w[i];
  endtask

  function automatic logic [15:0] rand_unit();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'h0061 + 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int draw_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // stimulus and prediction
  initial begin
    int n;
    int k;
    rst_n = 0;
    items_total = 0;
    lib_cnt = 0;
    pool_top = 0;
    ent_cnt = 0;
    nfill = 0;
    for (int i = 0; i < BUCKET_N; i++) begin
      head_ok[i] = 0;
      head_idx[i] = '0;
    end

    // directed: empty names, unit extremes, repeats, broken name, full-length and overlong names
    put_empty();
    put_empty();
    name_w[0] = 16'h0000; put_name(1);
    name_w[0] = 16'hFFFF; put_name(1);
    name_w[0] = 16'h0000; put_name(1);
    name_w[0] = 16'hFFFF; name_w[1] = 16'h0000; name_w[2] = 16'hFFFF; put_name(3);
    put_name(3);
    name_w[0] = 16'hFFFF; name_w[1] = 16'h0001; name_w[2] = 16'hFFFF; put_name(3);
    put_unit(16'h1234, 1'b0, 1'b0);
    put_unit(16'h5678, 1'b0, 1'b0);
    put_empty();
    for (int i = 0; i < 64; i++) name_w[i] = 16'($urandom);
    put_name(64);
    remember_name(64);
    put_name(64);
    for (int i = 0; i < 66; i++) name_w[i] = 16'($urandom);
    put_name(66);
    put_name(65);

    // random: mostly well formed names, repeats and near misses
    while (items_total < 1250) begin
      k = $urandom_range(0, 99);
      if (k < 35 && lib_cnt > 0) begin
        k = $urandom_range(0, lib_cnt - 1);
        for (int i = 0; i < lib_n[k]; i++) name_w[i] = lib_u[k][i];
        put_name(lib_n[k]);
      end else if (k < 50 && lib_cnt > 0) begin
        k = $urandom_range(0, lib_cnt - 1);
        n = lib_n[k];
        for (int i = 0; i < n; i++) name_w[i] = lib_u[k][i];
        if ($urandom_range(0, 1) && n > 0) begin
          k = $urandom_range(0, n - 1);
          name_w[k] ^= 16'(1 << $urandom_range(0, 15));
        end else if (n < NAME_MAX) begin
          name_w[n] = rand_unit();
          n++;
        end
        if (n == 0) begin
          name_w[0] = rand_unit();
          n = 1;
        end
        put_name(n);
        remember_name(n);
      end else if (k < 82) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        for (int i = 0; i < n; i++) name_w[i] = rand_unit();
        put_name(n);
        remember_name(n);
      end else if (k < 90) begin
        put_empty();
      end else if (k < 97) begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) put_unit(rand_unit(), 1'b0, 1'b0);
        put_empty();
      end else begin
        n = $urandom_range(65, 72);
        for (int i = 0; i < n; i++) name_w[i] = rand_unit();
        put_name(n);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    wait (items_taken == items_total && interned_q.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // input driver
  logic in_took;
  int   in_gap;
  bit   in_quiet;

  initial begin
    in_valid = 0;
    in_code_unit = '0;
    in_is_last = 0;
    in_empty_name = 0;
    in_gap = 0;
    in_quiet = 0;
    out_stall = 0;
  end

  always @(negedge clk) begin
    unit_item_t it;
    if (rst_n) begin
      if ($urandom_range(0, 299) == 0) in_quiet = !in_quiet;
      if (!in_valid || in_took) begin
        if (in_gap > 0) begin
          in_valid <= 0;
          in_gap--;
        end else if (unit_q.size() > 0) begin
          it = unit_q.pop_front();
          in_code_unit <= it.unit;
          in_is_last <= it.last;
          in_empty_name <= it.empty;
          in_valid <= 1;
          in_gap = draw_gap(in_quiet);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // result-side stall
  int out_hold;
  bit out_quiet;

  initial begin
    out_hold = 0;
    out_quiet = 0;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 299) == 0) out_quiet = !out_quiet;
      if (out_hold > 0) begin
        out_stall <= 1;
        out_hold--;
      end else begin
        out_stall <= 0;
        out_hold = draw_gap(out_quiet);
      end
    end
  end

  // monitor
  initial begin
    items_taken = 0;
    errors = 0;
    in_took = 0;
  end

  always @(posedge clk) begin
    intern_res_t x;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) items_taken++;
    if (rst_n && out_valid && !out_stall) begin
      if (interned_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        x = interned_q.pop_front();
        if (out_status !== x.st) begin
          $error("status expected %0d got %0d", x.st, out_status);
          errors++;
        end
        if (out_name_start !== x.start) begin
          $error("name_start expected %0d got %0d", x.start, out_name_start);
          errors++;
        end
        if (out_name_length !== x.len) begin
          $error("name_length expected %0d got %0d", x.len, out_name_length);
          errors++;
        end
        if (out_entry_id !== x.id) begin
          $error("entry_id expected %0d got %0d", x.id, out_entry_id);
          errors++;
        end
      end
    end
  end

endmodule
